>>> rtl/odo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Shared types, constants and the CORDIC arctangent table for the odometry
// controller, datapath and divider.
// ----------------------------------------------------------------------------
package odo_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEFT_MPT  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_MPT = 2'd1;
    localparam logic [1:0] CFG_TURN_GAIN = 2'd2;
    localparam logic [1:0] CFG_MIN_INT   = 2'd3;

    // Configuration reset values.
    localparam logic [23:0] LEFT_MPT_RST  = 24'd65536;
    localparam logic [23:0] RIGHT_MPT_RST = 24'd65536;
    localparam logic [23:0] TURN_GAIN_RST = 24'd6832291;
    localparam logic [15:0] MIN_INT_RST   = 16'd10;

    // CORDIC gain compensation in Q2.30 and the step index width.
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int STEP_W = 5;
    localparam int MAX_STEPS = 24;

    // Serial divider widths.
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;

    // Datapath operations, one per cycle.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CLEAR,
        OP_ACCUM,
        OP_MUL_DL,
        OP_MUL_DR,
        OP_SUMDIFF,
        OP_MUL_TLO,
        OP_MUL_THI,
        OP_THETA,
        OP_HEADING,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_MUL_SLO_SN,
        OP_MUL_SHI_SN,
        OP_MUL_SLO_CS,
        OP_MUL_SHI_CS,
        OP_DY,
        OP_Y_ADD,
        OP_SPEED_DONE,
        OP_TURN_DONE,
        OP_PUB,
        OP_PUB_UPD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [STEP_W-1:0]  step;
    } cmd_t;

    typedef struct packed {
        logic is_reset;
        logic due;
        logic div_busy;
    } stat_t;

    // Arctangent of 2^-i in Q2.30 binary angle units (half turn = 2^31).
    function automatic logic [29:0] atan_val(input logic [STEP_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// A pose update waits for the two serial divisions, which run one after the
// other on one divider. Throughput: one transaction at a time; the next is
// taken in the cycle after the result is loaded into the output register.
// Reset is asynchronous and active low; it loads the default configuration
// and clears the pose and timing state.
// ----------------------------------------------------------------------------
//
// The block integrates left and right encoder tick deltas into a pose. Each
// input transaction adds its deltas to saturating accumulators and adds the
// time since the previous transaction to an elapsed-time accumulator. Once
// the elapsed time reaches the minimum interval, the ticks are scaled into
// wheel distances with the shared multiplier, the heading advances by the
// distance difference times the turn gain, and a CORDIC rotation of the new
// heading gives sine and cosine for the x and y steps. Speed and turn rate
// come from the serial divider, which starts with the heading update and so
// overlaps the CORDIC steps. Every input transaction gives exactly one output
// transaction carrying the current pose.
//
// The controller and the datapath talk only through a command and a status
// struct. The output register lets a result wait for the consumer while the
// input side is free again.
module differential_drive_odometry
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [15:0] left_delta,
    input  logic signed [15:0] right_delta,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               updated,
    output logic signed [31:0] x_pos,
    output logic signed [31:0] y_pos,
    output logic [15:0]        heading_angle,
    output logic signed [23:0] speed_mm_s,
    output logic signed [23:0] turn_rate,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    odo_pkg::cmd_t  cmd;
    odo_pkg::stat_t stat;

    // Sequencer: handshakes and the per-cycle datapath operation.
    odo_ctrl
    #(
        .CORDIC_STEPS (CORDIC_STEPS)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic, state, configuration and the output register.
    odo_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .left_delta    (left_delta),
        .right_delta   (right_delta),
        .now_ms        (now_ms),
        .updated       (updated),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .heading_angle (heading_angle),
        .speed_mm_s    (speed_mm_s),
        .turn_rate     (turn_rate)
    );

endmodule

>>> rtl/odo_div.sv
// ----------------------------------------------------------------------------
// Odometry serial divider
// Restoring unsigned divider, one quotient bit per cycle, with a sign flag
// applied at the end and the result saturated to 24 signed bits.
// ----------------------------------------------------------------------------
module odo_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [odo_pkg::DIV_NUM_W-1:0]  num,
    input  logic [odo_pkg::DIV_DEN_W-1:0]  den,
    input  logic                           neg,
    output logic                           busy,
    output logic signed [23:0]             quot
);

    logic [odo_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic [odo_pkg::DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [odo_pkg::DIV_DEN_W:0]   rem_reg, rem_next;
    logic [odo_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic                          neg_reg, neg_next;
    logic [odo_pkg::DIV_DEN_W+1:0] trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        trial = {rem_reg, quo_reg[odo_pkg::DIV_NUM_W-1]} - {2'b00, den_reg};
        if (start)
        begin
            cnt_next  = odo_pkg::DIV_CNT_W'(odo_pkg::DIV_NUM_W);
            busy_next = 1'b1;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so its shifted value fits.
            if (!trial[odo_pkg::DIV_DEN_W+1])
            begin
                rem_next = trial[odo_pkg::DIV_DEN_W:0];
                quo_next = {quo_reg[odo_pkg::DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[odo_pkg::DIV_DEN_W-1:0], quo_reg[odo_pkg::DIV_NUM_W-1]};
                quo_next = {quo_reg[odo_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == odo_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > odo_pkg::DIV_NUM_W'(24'h800000))
                quot = 24'sh800000;
            else
                quot = -$signed(quo_reg[23:0]);
        end
        else
        begin
            if (quo_reg > odo_pkg::DIV_NUM_W'(24'h7FFFFF))
                quot = 24'sh7FFFFF;
            else
                quot = $signed(quo_reg[23:0]);
        end
    end

    assign busy = busy_reg;

endmodule

>>> rtl/odo_dp.sv
// ----------------------------------------------------------------------------
// Odometry datapath
// Configuration and pose registers, one shared registered multiplier, the
// CORDIC rotator, the serial divider and the output register.
// ----------------------------------------------------------------------------
module odo_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  odo_pkg::cmd_t       cmd,
    output odo_pkg::stat_t      stat,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                opcode,
    input  logic signed [15:0]  left_delta,
    input  logic signed [15:0]  right_delta,
    input  logic [31:0]         now_ms,
    output logic                updated,
    output logic signed [31:0]  x_pos,
    output logic signed [31:0]  y_pos,
    output logic [15:0]         heading_angle,
    output logic signed [23:0]  speed_mm_s,
    output logic signed [23:0]  turn_rate
);

    // Configuration.
    logic [23:0] lmpt_reg, rmpt_reg, gain_reg;
    logic [15:0] minint_reg;

    // Held input transaction.
    logic               op_hold_reg;
    logic signed [15:0] ld_reg, rd_reg;
    logic [31:0]        now_reg;

    // Odometry state.
    logic [31:0]        last_time_reg, elapsed_reg;
    logic signed [23:0] left_acc_reg, right_acc_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [15:0]        heading_reg;
    logic signed [23:0] speed_reg, turn_reg;

    // Work registers.
    logic signed [58:0] prod_reg, plo_reg;
    logic signed [47:0] dl_reg;
    logic signed [48:0] sum_reg;
    logic signed [38:0] diff_reg;
    logic signed [39:0] theta_reg;
    logic signed [32:0] s_reg;
    logic signed [59:0] sum1k_reg;
    logic [47:0]        spd_num_reg;
    logic               spd_neg_reg;
    logic signed [49:0] th1k_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               cneg_reg;
    logic signed [37:0] dxy_reg;

    // Output register.
    logic               upd_out_reg;
    logic signed [31:0] x_out_reg, y_out_reg;
    logic [15:0]        h_out_reg;
    logic signed [23:0] s_out_reg, t_out_reg;

    // Combinational helpers.
    logic signed [24:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [58:0] mul_p;
    logic signed [33:0] sn_val, cs_val;
    logic [32:0]        e_sum;
    logic signed [24:0] l_sum, r_sum;
    logic signed [47:0] dr_val;
    logic signed [48:0] dd_val;
    logic signed [40:0] dd_sh;
    logic signed [39:0] sum_sh;
    logic signed [65:0] th_full;
    logic signed [67:0] xy_full;
    logic signed [38:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic signed [59:0] sum1k_abs;
    logic signed [49:0] th1k_abs, th1k_val;
    logic [31:0]        cord_a;
    logic               cord_neg;
    logic signed [33:0] xs_val, ys_val, at_val;
    logic [15:0]        mn_eff;
    logic               div_start, div_busy;
    logic [47:0]        div_num;
    logic               div_neg;
    logic signed [23:0] div_q;

    assign sn_val = cneg_reg ? -cy_reg : cy_reg;
    assign cs_val = cneg_reg ? -cx_reg : cx_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            odo_pkg::OP_MUL_DL:
            begin
                mul_a = 25'(left_acc_reg);
                mul_b = $signed({10'b0, lmpt_reg});
            end
            odo_pkg::OP_MUL_DR:
            begin
                mul_a = 25'(right_acc_reg);
                mul_b = $signed({10'b0, rmpt_reg});
            end
            odo_pkg::OP_MUL_TLO:
            begin
                mul_a = $signed({5'b0, diff_reg[19:0]});
                mul_b = $signed({10'b0, gain_reg});
            end
            odo_pkg::OP_MUL_THI:
            begin
                mul_a = 25'($signed(diff_reg[38:20]));
                mul_b = $signed({10'b0, gain_reg});
            end
            odo_pkg::OP_MUL_SLO_SN:
            begin
                mul_a = $signed({9'b0, s_reg[15:0]});
                mul_b = sn_val;
            end
            odo_pkg::OP_MUL_SHI_SN:
            begin
                mul_a = 25'($signed(s_reg[32:16]));
                mul_b = sn_val;
            end
            odo_pkg::OP_MUL_SLO_CS:
            begin
                mul_a = $signed({9'b0, s_reg[15:0]});
                mul_b = cs_val;
            end
            odo_pkg::OP_MUL_SHI_CS:
            begin
                mul_a = 25'($signed(s_reg[32:16]));
                mul_b = cs_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 59'(mul_a) * 59'(mul_b);

    // Accumulation with saturation.
    assign e_sum = {1'b0, elapsed_reg} + {1'b0, now_reg - last_time_reg};
    assign l_sum = 25'(left_acc_reg) + 25'(ld_reg);
    assign r_sum = 25'(right_acc_reg) + 25'(rd_reg);

    // Wheel sums and differences.
    assign dr_val = $signed(prod_reg[47:0]);
    assign dd_val = 49'(dl_reg) - 49'(dr_val);
    assign dd_sh  = dd_val[48:8];
    assign sum_sh = sum_reg[48:9];

    // Recombining the partial products, with round half up.
    assign th_full = (66'(prod_reg) <<< 20) + 66'(plo_reg) + 66'sd8388608;
    assign xy_full = (68'(prod_reg) <<< 16) + 68'(plo_reg) + 68'sd536870912;

    // Saturating position add; the same adder serves x and y.
    assign pos_sum = (cmd.op == odo_pkg::OP_Y_ADD) ? 39'(y_reg) + 39'(dxy_reg)
                                                    : 39'(x_reg) + 39'(dxy_reg);
    always_comb
    begin
        if (pos_sum > 39'sd2147483647)
            pos_sat = 32'sh7FFFFFFF;
        else if (pos_sum < -39'sd2147483648)
            pos_sat = 32'sh80000000;
        else
            pos_sat = pos_sum[31:0];
    end

    assign sum1k_abs = sum1k_reg[59] ? -sum1k_reg : sum1k_reg;
    assign th1k_val  = (50'(theta_reg) <<< 10) - (50'(theta_reg) <<< 5) + (50'(theta_reg) <<< 3);
    assign th1k_abs  = th1k_reg[49] ? -th1k_reg : th1k_reg;

    // Angle fold: the second and third quarters are turned by a half turn.
    assign cord_a   = {heading_reg, 16'b0};
    assign cord_neg = (cord_a[31:30] == 2'b01) || (cord_a[31:30] == 2'b10);
    assign xs_val   = cx_reg >>> cmd.step;
    assign ys_val   = cy_reg >>> cmd.step;
    assign at_val   = $signed({4'b0, odo_pkg::atan_val(cmd.step)});

    assign mn_eff = (minint_reg == 16'd0) ? 16'd1 : minint_reg;

    // Divider: speed starts with the heading update, turn rate after speed.
    assign div_start = (cmd.op == odo_pkg::OP_HEADING) || (cmd.op == odo_pkg::OP_SPEED_DONE);
    assign div_num   = (cmd.op == odo_pkg::OP_HEADING) ? spd_num_reg : th1k_abs[47:0];
    assign div_neg   = (cmd.op == odo_pkg::OP_HEADING) ? spd_neg_reg : th1k_reg[49];

    odo_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (elapsed_reg),
        .neg   (div_neg),
        .busy  (div_busy),
        .quot  (div_q)
    );

    // Configuration and odometry state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmpt_reg      <= odo_pkg::LEFT_MPT_RST;
            rmpt_reg      <= odo_pkg::RIGHT_MPT_RST;
            gain_reg      <= odo_pkg::TURN_GAIN_RST;
            minint_reg    <= odo_pkg::MIN_INT_RST;
            last_time_reg <= '0;
            elapsed_reg   <= '0;
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            speed_reg     <= '0;
            turn_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    odo_pkg::CFG_LEFT_MPT:  lmpt_reg   <= cfg_data;
                    odo_pkg::CFG_RIGHT_MPT: rmpt_reg   <= cfg_data;
                    odo_pkg::CFG_TURN_GAIN: gain_reg   <= cfg_data;
                    odo_pkg::CFG_MIN_INT:   minint_reg <= cfg_data[15:0];
                endcase
            end
            unique case (cmd.op)
                odo_pkg::OP_CLEAR:
                begin
                    last_time_reg <= now_reg;
                    elapsed_reg   <= '0;
                    left_acc_reg  <= '0;
                    right_acc_reg <= '0;
                    x_reg         <= '0;
                    y_reg         <= '0;
                    heading_reg   <= '0;
                    speed_reg     <= '0;
                    turn_reg      <= '0;
                end
                odo_pkg::OP_ACCUM:
                begin
                    elapsed_reg   <= e_sum[32] ? 32'hFFFFFFFF : e_sum[31:0];
                    last_time_reg <= now_reg;
                    if (l_sum[24] != l_sum[23])
                        left_acc_reg <= l_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
                    else
                        left_acc_reg <= l_sum[23:0];
                    if (r_sum[24] != r_sum[23])
                        right_acc_reg <= r_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
                    else
                        right_acc_reg <= r_sum[23:0];
                end
                odo_pkg::OP_HEADING:
                begin
                    heading_reg <= heading_reg + theta_reg[15:0];
                end
                odo_pkg::OP_MUL_SHI_CS:
                begin
                    x_reg <= pos_sat;
                end
                odo_pkg::OP_Y_ADD:
                begin
                    y_reg <= pos_sat;
                end
                odo_pkg::OP_SPEED_DONE:
                begin
                    speed_reg <= div_q;
                end
                odo_pkg::OP_TURN_DONE:
                begin
                    turn_reg <= div_q;
                end
                odo_pkg::OP_PUB_UPD:
                begin
                    elapsed_reg   <= '0;
                    left_acc_reg  <= '0;
                    right_acc_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Work registers and output register.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        unique case (cmd.op)
            odo_pkg::OP_LOAD:
            begin
                op_hold_reg <= opcode;
                ld_reg      <= left_delta;
                rd_reg      <= right_delta;
                now_reg     <= now_ms;
            end
            odo_pkg::OP_MUL_DR:
            begin
                dl_reg <= prod_reg[47:0];
            end
            odo_pkg::OP_SUMDIFF:
            begin
                sum_reg <= 49'(dl_reg) + 49'(dr_val);
                if (dd_sh > 41'sd274877906943)
                    diff_reg <= 39'sd274877906943;
                else if (dd_sh < -41'sd274877906943)
                    diff_reg <= -39'sd274877906943;
                else
                    diff_reg <= dd_sh[38:0];
            end
            odo_pkg::OP_MUL_TLO:
            begin
                sum1k_reg <= (60'(sum_reg) <<< 10) - (60'(sum_reg) <<< 5)
                             + (60'(sum_reg) <<< 3);
                if (sum_sh > 40'sd4294967295)
                    s_reg <= 33'sd4294967295;
                else if (sum_sh < -40'sd4294967295)
                    s_reg <= -33'sd4294967295;
                else
                    s_reg <= sum_sh[32:0];
            end
            odo_pkg::OP_MUL_THI:
            begin
                plo_reg     <= prod_reg;
                spd_num_reg <= {5'b0, sum1k_abs[59:17]};
                spd_neg_reg <= sum1k_reg[59];
            end
            odo_pkg::OP_THETA:
            begin
                theta_reg <= th_full[63:24];
            end
            odo_pkg::OP_HEADING:
            begin
                th1k_reg <= th1k_val;
            end
            odo_pkg::OP_CORDIC_INIT:
            begin
                cx_reg   <= odo_pkg::CORDIC_GAIN;
                cy_reg   <= '0;
                cz_reg   <= 34'($signed(cord_neg ? (cord_a ^ 32'h80000000) : cord_a));
                cneg_reg <= cord_neg;
            end
            odo_pkg::OP_CORDIC_STEP:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - ys_val;
                    cy_reg <= cy_reg + xs_val;
                    cz_reg <= cz_reg - at_val;
                end
                else
                begin
                    cx_reg <= cx_reg + ys_val;
                    cy_reg <= cy_reg - xs_val;
                    cz_reg <= cz_reg + at_val;
                end
            end
            odo_pkg::OP_MUL_SHI_SN:
            begin
                plo_reg <= prod_reg;
            end
            odo_pkg::OP_MUL_SLO_CS:
            begin
                dxy_reg <= xy_full[67:30];
            end
            odo_pkg::OP_MUL_SHI_CS:
            begin
                plo_reg <= prod_reg;
            end
            odo_pkg::OP_DY:
            begin
                dxy_reg <= xy_full[67:30];
            end
            odo_pkg::OP_PUB, odo_pkg::OP_PUB_UPD:
            begin
                upd_out_reg <= (cmd.op == odo_pkg::OP_PUB_UPD);
                x_out_reg   <= x_reg;
                y_out_reg   <= y_reg;
                h_out_reg   <= heading_reg;
                s_out_reg   <= speed_reg;
                t_out_reg   <= turn_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.is_reset = op_hold_reg;
    assign stat.due      = (elapsed_reg >= {16'b0, mn_eff});
    assign stat.div_busy = div_busy;

    assign updated       = upd_out_reg;
    assign x_pos         = x_out_reg;
    assign y_pos         = y_out_reg;
    assign heading_angle = h_out_reg;
    assign speed_mm_s    = s_out_reg;
    assign turn_rate     = t_out_reg;

endmodule

>>> rtl/odo_ctrl.sv
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences the datapath through accumulation, pose update, CORDIC steps and
// the two divisions, and owns both handshakes.
// ----------------------------------------------------------------------------
module odo_ctrl
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  odo_pkg::stat_t     stat,
    output odo_pkg::cmd_t      cmd
);

    localparam int NSTEP = (CORDIC_STEPS < odo_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                                : odo_pkg::MAX_STEPS;
    localparam logic [odo_pkg::STEP_W-1:0] LAST_STEP = odo_pkg::STEP_W'(NSTEP - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_ACCUM, S_CHECK, S_MDL, S_MDR, S_SUMD, S_TLO, S_THI, S_THETA,
        S_HEAD, S_CINIT, S_CSTEP, S_XLO, S_XHI, S_YLO, S_YHI, S_DY, S_YADD,
        S_WSPD, S_WTURN, S_PUB
    } state_t;

    state_t                     state_reg, state_next;
    logic [odo_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       upd_reg, upd_next;
    logic                       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        upd_next       = upd_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = odo_pkg::OP_IDLE;
        cmd.step       = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = odo_pkg::OP_LOAD;
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                if (stat.is_reset)
                begin
                    cmd.op     = odo_pkg::OP_CLEAR;
                    upd_next   = 1'b0;
                    state_next = S_PUB;
                end
                else
                begin
                    cmd.op     = odo_pkg::OP_ACCUM;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                upd_next   = stat.due;
                state_next = stat.due ? S_MDL : S_PUB;
            end
            S_MDL:
            begin
                cmd.op     = odo_pkg::OP_MUL_DL;
                state_next = S_MDR;
            end
            S_MDR:
            begin
                cmd.op     = odo_pkg::OP_MUL_DR;
                state_next = S_SUMD;
            end
            S_SUMD:
            begin
                cmd.op     = odo_pkg::OP_SUMDIFF;
                state_next = S_TLO;
            end
            S_TLO:
            begin
                cmd.op     = odo_pkg::OP_MUL_TLO;
                state_next = S_THI;
            end
            S_THI:
            begin
                cmd.op     = odo_pkg::OP_MUL_THI;
                state_next = S_THETA;
            end
            S_THETA:
            begin
                cmd.op     = odo_pkg::OP_THETA;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.op     = odo_pkg::OP_HEADING;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.op     = odo_pkg::OP_CORDIC_INIT;
                step_next  = '0;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.op    = odo_pkg::OP_CORDIC_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_XLO;
                end
            end
            S_XLO:
            begin
                cmd.op     = odo_pkg::OP_MUL_SLO_SN;
                state_next = S_XHI;
            end
            S_XHI:
            begin
                cmd.op     = odo_pkg::OP_MUL_SHI_SN;
                state_next = S_YLO;
            end
            S_YLO:
            begin
                cmd.op     = odo_pkg::OP_MUL_SLO_CS;
                state_next = S_YHI;
            end
            S_YHI:
            begin
                cmd.op     = odo_pkg::OP_MUL_SHI_CS;
                state_next = S_DY;
            end
            S_DY:
            begin
                cmd.op     = odo_pkg::OP_DY;
                state_next = S_YADD;
            end
            S_YADD:
            begin
                cmd.op     = odo_pkg::OP_Y_ADD;
                state_next = S_WSPD;
            end
            S_WSPD:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = odo_pkg::OP_SPEED_DONE;
                    state_next = S_WTURN;
                end
            end
            S_WTURN:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = odo_pkg::OP_TURN_DONE;
                    state_next = S_PUB;
                end
            end
            S_PUB:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = upd_reg ? odo_pkg::OP_PUB_UPD : odo_pkg::OP_PUB;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            upd_reg       <= upd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> sim/odometry_checker.sv
// ----------------------------------------------------------------------------
// Odometry checker
// Watches the input, output and configuration ports of the odometry block.
// It keeps its own copy of the pose, timing and configuration, predicts one
// result for every accepted input transaction and compares it field by field.
// ----------------------------------------------------------------------------
module odometry_checker
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               opcode,
    input  logic signed [15:0] left_delta,
    input  logic signed [15:0] right_delta,
    input  logic [31:0]        now_ms,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               updated,
    input  logic signed [31:0] x_pos,
    input  logic signed [31:0] y_pos,
    input  logic [15:0]        heading_angle,
    input  logic signed [23:0] speed_mm_s,
    input  logic signed [23:0] turn_rate,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output int                 failures,
    output int                 pending,
    output int                 pose_updates
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        updated;
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        logic [23:0] speed;
        logic [23:0] turn;
    } pose_t;

    localparam longint ACC_HI  = 64'sd8388607;
    localparam longint ACC_LO  = -64'sd8388608;
    localparam longint DIFF_HI = 64'sd274877906943;
    localparam longint STEP_HI = 64'sd4294967295;
    localparam longint GAIN_Q30 = 64'sd652032874;

    longint arctan_q30 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    logic [23:0] left_scale, right_scale, gain;
    logic [15:0] min_ms;
    logic [31:0] prev_ms, elapsed_ms;
    longint      left_ticks, right_ticks, x_acc, y_acc, speed_st, turn_st;
    logic [15:0] heading;
    pose_t       expected_poses [$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Rotation of the gain vector to the heading; second and third quarter
    // angles are folded by a half turn and the results negated afterwards.
    task automatic sin_cos(input logic [15:0] hd, output longint sn, output longint cs);
        logic [31:0] a;
        logic        flip;
        longint      xv, yv, zv, xs, ys;
        a = {hd, 16'h0000};
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip)
            a = a ^ 32'h8000_0000;
        zv = longint'($signed(a));
        xv = GAIN_Q30;
        yv = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (zv >= 0)
            begin
                xv = xv - ys; yv = yv + xs; zv = zv - arctan_q30[i];
            end
            else
            begin
                xv = xv + ys; yv = yv - xs; zv = zv + arctan_q30[i];
            end
        end
        sn = flip ? -yv : yv;
        cs = flip ? -xv : xv;
    endtask

    task automatic integrate(input logic op, input logic signed [15:0] ld,
                             input logic signed [15:0] rd, input logic [31:0] stamp);
        pose_t       r;
        longint      e, el, dl, dr, sum, diff, theta, s, sn, cs;
        logic [31:0] floor_ms;
        logic [31:0] gap;
        r = '0;
        if (op)
        begin
            prev_ms = stamp; elapsed_ms = 0;
            left_ticks = 0; right_ticks = 0;
            x_acc = 0; y_acc = 0; heading = 0;
            speed_st = 0; turn_st = 0;
        end
        else
        begin
            // The time difference wraps at 32 bits when the clock goes backwards.
            gap = stamp - prev_ms;
            e = longint'(elapsed_ms) + longint'(gap);
            elapsed_ms = (e > 64'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
            floor_ms = (min_ms == 0) ? 32'd1 : {16'd0, min_ms};
            left_ticks = clip(left_ticks + longint'(ld), ACC_LO, ACC_HI);
            right_ticks = clip(right_ticks + longint'(rd), ACC_LO, ACC_HI);
            prev_ms = stamp;
            if (elapsed_ms >= floor_ms)
            begin
                el = longint'(elapsed_ms);
                dl = left_ticks * longint'(left_scale);
                dr = right_ticks * longint'(right_scale);
                sum = dl + dr;
                diff = clip((dl - dr) >>> 8, -DIFF_HI, DIFF_HI);
                theta = (diff * longint'(gain) + 64'sd8388608) >>> 24;
                s = clip(sum >>> 9, -STEP_HI, STEP_HI);
                heading = heading + theta[15:0];
                speed_st = clip((sum * 1000) / (el * 131072), ACC_LO, ACC_HI);
                turn_st = clip((theta * 1000) / el, ACC_LO, ACC_HI);
                sin_cos(heading, sn, cs);
                x_acc = clip(x_acc + ((s * sn + 64'sd536870912) >>> 30),
                             -64'sd2147483648, 64'sd2147483647);
                y_acc = clip(y_acc + ((s * cs + 64'sd536870912) >>> 30),
                             -64'sd2147483648, 64'sd2147483647);
                elapsed_ms = 0; left_ticks = 0; right_ticks = 0;
                r.updated = 1'b1;
            end
        end
        r.x = x_acc[31:0];
        r.y = y_acc[31:0];
        r.heading = heading;
        r.speed = speed_st[23:0];
        r.turn = turn_st[23:0];
        expected_poses.push_back(r);
    endtask

    assign pending = expected_poses.size();

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want;
        if (!rst_n)
        begin
            left_scale <= odo_pkg::LEFT_MPT_RST;
            right_scale <= odo_pkg::RIGHT_MPT_RST;
            gain <= odo_pkg::TURN_GAIN_RST;
            min_ms <= odo_pkg::MIN_INT_RST;
            prev_ms = 0; elapsed_ms = 0;
            left_ticks = 0; right_ticks = 0;
            x_acc = 0; y_acc = 0; heading = 0;
            speed_st = 0; turn_st = 0;
            failures <= 0;
            pose_updates <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    odo_pkg::CFG_LEFT_MPT:  left_scale <= cfg_data;
                    odo_pkg::CFG_RIGHT_MPT: right_scale <= cfg_data;
                    odo_pkg::CFG_TURN_GAIN: gain <= cfg_data;
                    odo_pkg::CFG_MIN_INT:   min_ms <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                integrate(opcode, left_delta, right_delta, now_ms);
            if (out_valid && !out_stall)
            begin
                if (expected_poses.size() == 0)
                begin
                    $error("result transaction arrived with nothing expected");
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (updated)
                        pose_updates <= pose_updates + 1;
                    if (updated !== want.updated)
                        $error("updated: expected %0d, got %0d", want.updated, updated);
                    if (x_pos !== want.x)
                        $error("x_pos: expected %0d, got %0d", $signed(want.x), x_pos);
                    if (y_pos !== want.y)
                        $error("y_pos: expected %0d, got %0d", $signed(want.y), y_pos);
                    if (heading_angle !== want.heading)
                        $error("heading_angle: expected %0d, got %0d",
                               want.heading, heading_angle);
                    if (speed_mm_s !== want.speed)
                        $error("speed_mm_s: expected %0d, got %0d",
                               $signed(want.speed), speed_mm_s);
                    if (turn_rate !== want.turn)
                        $error("turn_rate: expected %0d, got %0d",
                               $signed(want.turn), turn_rate);
                    if ({updated, x_pos, y_pos, heading_angle, speed_mm_s, turn_rate}
                        !== want)
                        failures <= failures + 1;
                end
            end
        end
    end

endmodule

>>> sim/differential_drive_odometry_test.sv
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives directed and random encoder transactions through the odometry block
// under several configurations, with bursty input and a stalling consumer.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_STEPS = 16;
    // The limit lies well above what a correct run needs, stalls included, and
    // also covers the long consumer hold-off.
    localparam int CYCLE_LIMIT = 2000000;
    // Worst case drain time of one transaction that updates the pose.
    localparam int DRAIN_CYCLES = 150;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               opcode = 1'b0;
    logic signed [15:0] left_delta = '0;
    logic signed [15:0] right_delta = '0;
    logic [31:0]        now_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               updated;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [15:0]        heading_angle;
    logic signed [23:0] speed_mm_s;
    logic signed [23:0] turn_rate;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [23:0]        cfg_data = '0;

    int failures;
    int pending;
    int pose_updates;
    int sent_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    logic [31:0] stamp_ms = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    differential_drive_odometry #(.CORDIC_STEPS(CORDIC_STEPS)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .left_delta(left_delta), .right_delta(right_delta),
        .now_ms(now_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .updated(updated), .x_pos(x_pos), .y_pos(y_pos),
        .heading_angle(heading_angle), .speed_mm_s(speed_mm_s),
        .turn_rate(turn_rate),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    odometry_checker #(.CORDIC_STEPS(CORDIC_STEPS)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .left_delta(left_delta), .right_delta(right_delta),
        .now_ms(now_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .updated(updated), .x_pos(x_pos), .y_pos(y_pos),
        .heading_angle(heading_angle), .speed_mm_s(speed_mm_s),
        .turn_rate(turn_rate),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending), .pose_updates(pose_updates)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The consumer switches between stall patterns: no stall, light
    // or heavy random stalls. Once, early in the random part, it holds off for
    // a long stretch so that the output register fills and the block stalls
    // its input while transactions are still being offered.
    initial
    begin
        int mode;
        int held;
        mode = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (cycle_count % 64 == 0)
                mode = $urandom_range(0, 3);
            if (held == 0 && cycle_count > 6000)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                held = 1;
            end
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 8);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Offers one transaction and returns at the edge where it was taken, or at
    // the end of the gap that follows it. Called right after a rising edge; valid
    // stays high into the next call when no gap follows.
    task automatic offer(input logic op, input logic [15:0] ld, input logic [15:0] rd,
                         input logic [31:0] stamp);
        in_valid <= 1'b1;
        opcode <= op;
        left_delta <= ld;
        right_delta <= rd;
        now_ms <= stamp;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
        // The sender works in bursts; a gap lowers valid for a while.
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Configuration is only written with no transaction in flight. Results
    // always arrive, so an empty expectation queue plus the drain time of one
    // update means the block is idle. One edge passes first so that the
    // checker has counted the last accepted transaction.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [23:0] lscale, input logic [23:0] rscale,
                             input logic [23:0] tgain, input logic [15:0] min_int);
        logic [1:0]  idx [4];
        logic [23:0] val [4];
        idx = '{odo_pkg::CFG_LEFT_MPT, odo_pkg::CFG_RIGHT_MPT, odo_pkg::CFG_TURN_GAIN,
                odo_pkg::CFG_MIN_INT};
        val = '{lscale, rscale, tgain, {8'd0, min_int}};
        settle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One random transaction. Most are ticks a few milliseconds apart with
    // moderate deltas; some carry full-range or extreme deltas, some jump the
    // clock anywhere (including backwards), and a few reset the pose.
    task automatic random_item();
        int pick;
        logic [15:0] ld, rd;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            stamp_ms = $urandom;
            offer(1'b1, 16'($urandom), 16'($urandom), stamp_ms);
        end
        else
        begin
            if (pick < 9)
                stamp_ms = $urandom;
            else
                stamp_ms = stamp_ms + $urandom_range(0, 8);
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                ld = 16'($urandom);
                rd = 16'($urandom);
            end
            else if (pick < 16)
            begin
                ld = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                rd = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            else
            begin
                ld = 16'($urandom_range(0, 600) - 300);
                rd = 16'($urandom_range(0, 600) - 300);
            end
            offer(1'b0, ld, rd, stamp_ms);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset configuration: extreme deltas both ways,
        // a sub-interval item, the pose reset opcode, time going backwards,
        // time wrapping past zero, and a sweep of the heading through all
        // four quarters.
        offer(1'b0, 16'h0000, 16'h0000, 32'd0);
        offer(1'b0, 16'h7FFF, 16'h7FFF, 32'd20);
        offer(1'b0, 16'h8000, 16'h8000, 32'd40);
        offer(1'b0, 16'h7FFF, 16'h8000, 32'd60);
        offer(1'b0, 16'h8000, 16'h7FFF, 32'd80);
        offer(1'b1, 16'h1234, 16'h4321, 32'd1000);
        offer(1'b0, 16'd5, 16'd3, 32'd1005);
        offer(1'b0, 16'd5, 16'd3, 32'd1010);
        offer(1'b0, 16'd7, 16'd9, 32'd500);
        offer(1'b0, 16'd1, 16'd2, 32'hFFFF_FFFF);
        offer(1'b0, 16'd1, 16'd2, 32'd3);
        for (int i = 0; i < 10; i++)
            offer(1'b0, 16'd3000, -16'sd3000, 32'd20 + 32'(i) * 32'd10);
        offer(1'b1, 16'h0000, 16'h0000, 32'hFFFF_FFF0);
        offer(1'b0, 16'h0100, 16'h0080, 32'h0000_0010);
        stamp_ms = 32'h10;

        // Random phases, each under its own configuration: defaults, mixed
        // extremes with a zero interval, the opposite extremes with the
        // longest interval, random values, the smallest values, and the reset
        // values again.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: configure(24'hFF_FFFF, 24'h00_0000, 24'hFF_FFFF, 16'd0);
                2: configure(24'h00_0000, 24'hFF_FFFF, 24'h00_0000, 16'hFFFF);
                3: configure(24'($urandom), 24'($urandom), 24'($urandom),
                             16'($urandom_range(1, 40)));
                4: configure(24'd1, 24'd1, 24'd1, 16'd1);
                5: configure(odo_pkg::LEFT_MPT_RST, odo_pkg::RIGHT_MPT_RST,
                             odo_pkg::TURN_GAIN_RST, odo_pkg::MIN_INT_RST);
                default: ;
            endcase
            repeat (140) random_item();
        end

        settle();
        $display("Sent %0d transactions across six configurations; %0d updated the pose.",
                 sent_count, pose_updates);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
